// ===== hw/rtl/gbba_pkg.sv =====
// Shared types, constants and helpers for the grouped bitmap block allocator.
// No dependencies; every other file in hw/rtl uses this package.
package gbba_pkg;

   localparam int BLOCK_W    = 17;
   localparam int STATUS_W   = 2;
   localparam int BPG_W      = 14;
   localparam int GCNT_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam int DEF_MAX_GROUPS = 8;
   localparam int DEF_GROUP_BITS = 8192;
   localparam int DEF_MEM_DEPTH  = DEF_MAX_GROUPS * ((DEF_GROUP_BITS + 7) / 8);
   localparam int DEF_MEM_AW     = $clog2(DEF_MEM_DEPTH);

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPC   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVAL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOMOUNT = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MOUNTED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DATA = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BPG        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GCOUNT     = 3'd4;

   localparam logic [BPG_W-1:0]   GRP_CNT_MAX = 14'h3FFF;
   localparam logic [BLOCK_W-1:0] TOT_CNT_MAX = 17'h1FFFF;
   localparam logic [7:0]         BYTE_FULL   = 8'hFF;

   typedef struct packed {
      logic done;
      logic invalid;
   } loc_status_type;

   // Lowest clear bit of a byte: bit 3 set means none, bits 2:0 the position.
   function automatic logic [3:0] first_zero(input logic [7:0] d);
      logic [3:0] r;
      r = 4'b1000;
      for (int k = 7; k >= 0; k--) begin
         if (!d[k]) begin
            r = {1'b0, 3'(k)};
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/grouped_bitmap_block_allocator.sv =====
// First-fit block allocator over a grouped used-bit map held in one byte-wide RAM.
// Depends on gbba_pkg, gbba_bitmap_ram and gbba_locate.
//
// Send one beat per request: tuser is the opcode (allocate or free), tdata the block
// number to free. Each request returns one beat with status in tuser and the granted
// block plus the running in-use count in tdata. After reset the block sweeps the
// bitmap RAM to zero, one byte a cycle, and takes no request until done; register
// writes are taken throughout. An allocate visits the groups in order, skipping
// full ones, and reads the bitmap bytes of a group one by one; a free goes through
// the group locator (repeated subtraction), then a RAM read and a write-back of the
// byte; a request while not mounted goes straight to the response.
// A new request is accepted while the previous response still waits on rsp_tready.
module grouped_bitmap_block_allocator #(
   parameter int MAX_GROUPS = gbba_pkg::DEF_MAX_GROUPS,
   parameter int GROUP_BITS = gbba_pkg::DEF_GROUP_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,  // [16:0] block_number
   input  logic [0:0]                      req_tuser,  // [0] opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,  // [16:0] allocated_block,
                                                       // [33:17] blocks_in_use
   output logic [1:0]                      rsp_tuser,  // [1:0] status
   input  logic                            csr_we,
   input  logic [gbba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbba_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gbba_pkg::*;

   localparam int GROUP_BYTES = (GROUP_BITS + 7) / 8;
   localparam int DEPTH = MAX_GROUPS * GROUP_BYTES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW    = $clog2(GROUP_BITS + 1);
   localparam int BYW   = $clog2(GROUP_BYTES + 1);
   localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int NGW   = $clog2(MAX_GROUPS + 1);
   localparam int BASEW = $clog2(MAX_GROUPS * GROUP_BITS + 1);
   localparam int DW    = ((BASEW > BLOCK_W) ? BASEW : BLOCK_W) + 2;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_GROUP, S_SCAN, S_LOCATE, S_FREAD, S_FCHECK, S_DONE
   } state_type;

   // Configuration registers
   logic               mounted_ff;
   logic               fdb_ff;
   logic [BPG_W-1:0]   bpg_ff;
   logic [BLOCK_W-1:0] total_ff;
   logic [GCNT_W-1:0]  gcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mounted_ff <= 1'b0;
         fdb_ff     <= 1'b1;
         bpg_ff     <= BPG_W'(8192);
         total_ff   <= BLOCK_W'(8193);
         gcount_ff  <= GCNT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MOUNTED:    mounted_ff <= csr_wdata[0];
            CSR_FIRST_DATA: fdb_ff     <= csr_wdata[0];
            CSR_BPG:        bpg_ff     <= csr_wdata[BPG_W-1:0];
            CSR_TOTAL:      total_ff   <= csr_wdata[BLOCK_W-1:0];
            CSR_GCOUNT:     gcount_ff  <= csr_wdata[GCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp group size and group count into the built range
   logic [BW-1:0]  bpg_eff;
   logic [NGW-1:0] ng_eff;

   always_comb begin
      if (bpg_ff < BPG_W'(8)) begin
         bpg_eff = BW'(8);
      end else if (32'(bpg_ff) > GROUP_BITS) begin
         bpg_eff = BW'(GROUP_BITS);
      end else begin
         bpg_eff = BW'(bpg_ff);
      end
      if (32'(gcount_ff) > MAX_GROUPS) begin
         ng_eff = NGW'(MAX_GROUPS);
      end else begin
         ng_eff = NGW'(gcount_ff);
      end
   end

   // Sequencer state
   state_type           state_ff;
   logic [AW-1:0]       clr_ff;
   logic [NGW-1:0]      g_ff;
   logic [BASEW-1:0]    base_ff;
   logic [BW-1:0]       maxb_ff;
   logic [BYW-1:0]      byte_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [BLOCK_W-1:0]  res_block_ff;
   logic [BPG_W-1:0]    grp_used_ff [MAX_GROUPS];
   logic [BLOCK_W-1:0]  total_used_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BLOCK_W-1:0]  rsp_block_ff;
   logic [BLOCK_W-1:0]  rsp_used_ff;

   // RAM and locator hookup
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [7:0]     mem_wdata, mem_rdata;
   logic           loc_start;
   loc_status_type loc_status;
   logic [GW-1:0]  loc_group;
   logic [BW-1:0]  loc_offset;

   gbba_bitmap_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   logic                accept;
   logic [BLOCK_W-1:0]  req_bn;
   logic                bn_bad;

   assign accept = req_tvalid && req_tready;
   assign req_bn = req_tdata[BLOCK_W-1:0];
   assign bn_bad = (req_bn < BLOCK_W'(fdb_ff)) || (req_bn >= total_ff);
   assign loc_start = accept && mounted_ff && (req_tuser[0] == OP_FREE) && !bn_bad;

   gbba_locate #(
      .MAX_GROUPS (MAX_GROUPS),
      .GROUP_BITS (GROUP_BITS),
      .BW         (BW),
      .NGW        (NGW),
      .GW         (GW)
   ) u_locate (
      .clock  (clock),
      .reset  (reset),
      .start  (loc_start),
      .rel    (req_bn - BLOCK_W'(fdb_ff)),
      .bpg    (bpg_eff),
      .ng     (ng_eff),
      .status (loc_status),
      .group  (loc_group),
      .offset (loc_offset)
   );

   // Group view: size of the current group, cut short on the last one
   logic [GW-1:0]  gi;
   logic [31:0]    grp_base_addr;
   logic [DW-1:0]  diff;
   logic           is_last;
   logic [BW-1:0]  maxb_n;
   logic           group_full;

   assign gi            = g_ff[GW-1:0];
   assign grp_base_addr = 32'(gi) * 32'(GROUP_BYTES);
   assign diff    = DW'(total_ff) - DW'(fdb_ff) - DW'(base_ff);
   assign is_last = (g_ff == (ng_eff - NGW'(1)));
   assign maxb_n  = (is_last && !diff[DW-1] && (diff < DW'(bpg_eff))) ? BW'(diff) : bpg_eff;
   assign group_full = DW'(grp_used_ff[gi]) >= DW'(maxb_n);

   // Byte scan view
   logic [BYW+2:0] ipos;
   logic [3:0]     fz;
   logic [DW-1:0]  cand;
   logic [DW-1:0]  bn_c;
   logic           pos_past, cand_past, over;

   assign ipos      = {byte_ff, 3'b000};
   assign fz        = first_zero(mem_rdata);
   assign cand      = DW'(ipos) + DW'(fz[2:0]);
   assign bn_c      = DW'(fdb_ff) + DW'(base_ff) + cand;
   assign pos_past  = DW'(ipos) >= DW'(maxb_ff);
   assign cand_past = cand >= DW'(maxb_ff);
   assign over      = bn_c >= DW'(total_ff);

   // Free path view
   logic [31:0] free_addr;
   logic [2:0]  fbit;

   assign free_addr = 32'(loc_group) * 32'(GROUP_BYTES) + 32'(loc_offset[BW-1:3]);
   assign fbit      = loc_offset[2:0];

   // RAM port drive
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(free_addr);
      mem_wdata = mem_rdata & ~(8'b1 << fbit);
      mem_raddr = AW'(grp_base_addr);
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         S_SCAN: begin
            mem_raddr = AW'(grp_base_addr + 32'(byte_ff) + 32'd1);
            mem_waddr = AW'(grp_base_addr + 32'(byte_ff));
            mem_wdata = mem_rdata | (8'b1 << fz[2:0]);
            // Claim the bit when the byte has a usable clear bit inside the volume
            mem_we    = !pos_past && !fz[3] && !cand_past && !over;
         end
         S_FREAD: begin
            mem_raddr = AW'(free_addr);
         end
         S_FCHECK: begin
            mem_we = mem_rdata[fbit];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         total_used_ff <= '0;
         for (int k = 0; k < MAX_GROUPS; k++) begin
            grp_used_ff[k] <= '0;
         end
      end else begin
         // Drop the beat once taken, unless a new result loads this cycle
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (32'(clr_ff) == DEPTH - 1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  g_ff         <= '0;
                  base_ff      <= '0;
                  res_block_ff <= '0;
                  if (!mounted_ff) begin
                     res_status_ff <= ST_NOMOUNT;
                     state_ff      <= S_DONE;
                  end else if (req_tuser[0] == OP_ALLOC) begin
                     state_ff <= S_GROUP;
                  end else if (bn_bad) begin
                     res_status_ff <= ST_INVAL;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_LOCATE;
                  end
               end
            end
            S_GROUP: begin
               priority if (g_ff >= ng_eff) begin
                  res_status_ff <= ST_NOSPC;
                  state_ff      <= S_DONE;
               end else if (group_full) begin
                  // Skip a group whose count already covers it
                  g_ff    <= g_ff + NGW'(1);
                  base_ff <= base_ff + BASEW'(bpg_eff);
               end else begin
                  maxb_ff  <= maxb_n;
                  byte_ff  <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               priority if (pos_past || (!fz[3] && cand_past)) begin
                  g_ff     <= g_ff + NGW'(1);
                  base_ff  <= base_ff + BASEW'(bpg_eff);
                  state_ff <= S_GROUP;
               end else if (fz[3]) begin
                  byte_ff <= byte_ff + BYW'(1);
               end else if (over) begin
                  res_status_ff <= ST_NOSPC;
                  state_ff      <= S_DONE;
               end else begin
                  res_status_ff <= ST_OK;
                  res_block_ff  <= BLOCK_W'(bn_c);
                  if (grp_used_ff[gi] < GRP_CNT_MAX) begin
                     grp_used_ff[gi] <= grp_used_ff[gi] + BPG_W'(1);
                  end
                  if (total_used_ff < TOT_CNT_MAX) begin
                     total_used_ff <= total_used_ff + BLOCK_W'(1);
                  end
                  state_ff <= S_DONE;
               end
            end
            S_LOCATE: begin
               if (loc_status.done) begin
                  if (loc_status.invalid) begin
                     res_status_ff <= ST_INVAL;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_FREAD;
                  end
               end
            end
            S_FREAD: begin
               state_ff <= S_FCHECK;
            end
            S_FCHECK: begin
               res_status_ff <= ST_OK;
               if (mem_rdata[fbit]) begin
                  if (grp_used_ff[loc_group] != '0) begin
                     grp_used_ff[loc_group] <= grp_used_ff[loc_group] - BPG_W'(1);
                  end
                  if (total_used_ff != '0) begin
                     total_used_ff <= total_used_ff - BLOCK_W'(1);
                  end
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // Hold the result until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_block_ff  <= (res_status_ff == ST_OK) ? res_block_ff : '0;
                  rsp_used_ff   <= total_used_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'b0, rsp_used_ff, rsp_block_ff};
endmodule

// ===== hw/rtl/gbba_bitmap_ram.sv =====
// Byte-wide used-bit map storage: one write port, one registered read port.
// Depends on gbba_pkg for default sizes.
module gbba_bitmap_ram #(
   parameter int DEPTH = gbba_pkg::DEF_MEM_DEPTH,
   parameter int AW    = gbba_pkg::DEF_MEM_AW
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/gbba_locate.sv =====
// Splits a relative block number into group and offset by repeated subtraction.
// Depends on gbba_pkg for widths and the status struct.
module gbba_locate #(
   parameter int MAX_GROUPS = gbba_pkg::DEF_MAX_GROUPS,
   parameter int GROUP_BITS = gbba_pkg::DEF_GROUP_BITS,
   parameter int BW  = $clog2(GROUP_BITS + 1),
   parameter int NGW = $clog2(MAX_GROUPS + 1),
   parameter int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gbba_pkg::BLOCK_W-1:0]   rel,
   input  logic [BW-1:0]                  bpg,
   input  logic [NGW-1:0]                 ng,
   output gbba_pkg::loc_status_type       status,
   output logic [GW-1:0]                  group,
   output logic [BW-1:0]                  offset
);
   import gbba_pkg::*;

   logic [BLOCK_W-1:0] rem_ff, rem_in;
   logic [NGW-1:0]     g_ff, g_in;
   logic               busy_ff, busy_in;
   loc_status_type     st_ff, st_in;

   always_comb begin
      rem_in  = rem_ff;
      g_in    = g_ff;
      busy_in = busy_ff;
      st_in   = st_ff;
      if (start) begin
         rem_in  = rel;
         g_in    = '0;
         busy_in = 1'b1;
         st_in   = '0;
      end else if (busy_ff) begin
         if (g_ff >= ng) begin
            busy_in       = 1'b0;
            st_in.done    = 1'b1;
            st_in.invalid = 1'b1;
         end else if (rem_ff < BLOCK_W'(bpg)) begin
            busy_in    = 1'b0;
            st_in.done = 1'b1;
         end else begin
            rem_in = rem_ff - BLOCK_W'(bpg);
            g_in   = g_ff + NGW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         st_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         st_ff   <= st_in;
      end
      rem_ff <= rem_in;
      g_ff   <= g_in;
   end

   assign status = st_ff;
   assign group  = g_ff[GW-1:0];
   assign offset = rem_ff[BW-1:0];
endmodule
